// File: rtl/wdaa_pkg.sv
package wdaa_pkg;

    localparam int TIME_BITS     = 32;
    localparam int INTERVAL_BITS = 16;
    localparam int TEMP_BITS     = 16;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [INTERVAL_BITS-1:0] AVERAGE_INTERVAL_RESET = 16'd1000;
    localparam logic [INTERVAL_BITS-1:0] TEMP_INTERVAL_RESET    = 16'd750;

    typedef enum logic [0:0] {
        REG_AVERAGE_INTERVAL = 1'b0,
        REG_TEMP_INTERVAL    = 1'b1
    } wdaa_reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_DONE
    } wdaa_state_t;

endpackage

// File: rtl/wdaa_in_if.sv
interface wdaa_in_if
    import wdaa_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
);
    logic                        valid;
    logic                        ready;
    logic [TIME_BITS-1:0]        now_ms;
    logic [SAMPLE_BITS-1:0]      sample_a;
    logic [SAMPLE_BITS-1:0]      sample_b;
    logic signed [TEMP_BITS-1:0] temp_raw;

    modport source (output valid, output now_ms, output sample_a, output sample_b,
                    output temp_raw, input ready);
    modport sink   (input valid, input now_ms, input sample_a, input sample_b,
                    input temp_raw, output ready);
endinterface

// File: rtl/wdaa_out_if.sv
interface wdaa_out_if
    import wdaa_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
);
    logic                        valid;
    logic                        ready;
    logic [SAMPLE_BITS-1:0]      average_a;
    logic [SAMPLE_BITS-1:0]      average_b;
    logic signed [TEMP_BITS-1:0] temperature;

    modport source (output valid, output average_a, output average_b,
                    output temperature, input ready);
    modport sink   (input valid, input average_a, input average_b,
                    input temperature, output ready);
endinterface

// File: rtl/windowed_dual_adc_averager.sv
// Boxcar averager for two converter channels with a temperature latch. Each
// input word adds its two samples to running sums; when the average interval
// has passed since the window start the sums are divided by the sample count
// and held, and when the temperature interval has passed the raw temperature
// is latched. Every input word yields one output word with the three held
// values. A word that does not close the window goes from the update state
// straight to completion; one that closes it first passes through the single
// restoring divider, which produces one quotient bit per cycle and serves both
// channels in turn. The result is registered in the completion state, and a
// stalled output register holds the word there. The input is not ready while
// a word is in progress. Configuration writes take effect at once.
module windowed_dual_adc_averager
    import wdaa_pkg::*;
#(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    wdaa_in_if.sink                  sample_ch,
    wdaa_out_if.source               result_ch,
    input  logic                     cfg_we,
    input  wdaa_reg_index_t          cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
    localparam int STEP_BITS = $clog2(SAMPLE_BITS);
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(SAMPLE_BITS - 1);

    wdaa_state_t state_reg, state_next;

    logic [INTERVAL_BITS-1:0] avg_interval_reg, avg_interval_next;
    logic [INTERVAL_BITS-1:0] temp_interval_reg, temp_interval_next;

    logic [TIME_BITS-1:0]        now_reg;
    logic [SAMPLE_BITS-1:0]      a_reg;
    logic [SAMPLE_BITS-1:0]      b_reg;
    logic signed [TEMP_BITS-1:0] traw_reg;

    logic [SUM_BITS-1:0]         sum_a_reg, sum_a_next;
    logic [SUM_BITS-1:0]         sum_b_reg, sum_b_next;
    logic [COUNT_BITS-1:0]       count_reg, count_next;
    logic [TIME_BITS-1:0]        window_start_reg, window_start_next;
    logic [TIME_BITS-1:0]        temp_start_reg, temp_start_next;
    logic [SAMPLE_BITS-1:0]      held_a_reg, held_a_next;
    logic [SAMPLE_BITS-1:0]      held_b_reg, held_b_next;
    logic signed [TEMP_BITS-1:0] held_temp_reg, held_temp_next;

    // divider
    logic [COUNT_BITS-1:0]  rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] quo_reg, quo_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic                   chan_b_reg, chan_b_next;

    logic                        out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]      out_a_reg, out_a_next;
    logic [SAMPLE_BITS-1:0]      out_b_reg, out_b_next;
    logic signed [TEMP_BITS-1:0] out_temp_reg, out_temp_next;

    logic [TIME_BITS-1:0]  window_elapsed;
    logic [TIME_BITS-1:0]  temp_elapsed;
    logic                  window_close;
    logic                  temp_due;
    logic [SUM_BITS-1:0]   acc_a;
    logic [SUM_BITS-1:0]   acc_b;
    logic [COUNT_BITS-1:0] acc_count;
    logic [COUNT_BITS:0]   trial_shift;
    logic [COUNT_BITS:0]   trial_diff;
    logic [SUM_BITS-1:0]   div_sum;

    assign sample_ch.ready       = (state_reg == ST_IDLE);
    assign result_ch.valid       = out_valid_reg;
    assign result_ch.average_a   = out_a_reg;
    assign result_ch.average_b   = out_b_reg;
    assign result_ch.temperature = out_temp_reg;

    assign window_elapsed = now_reg - window_start_reg;
    assign temp_elapsed   = now_reg - temp_start_reg;
    assign window_close   = window_elapsed >= {{(TIME_BITS-INTERVAL_BITS){1'b0}}, avg_interval_reg};
    assign temp_due       = temp_elapsed >= {{(TIME_BITS-INTERVAL_BITS){1'b0}}, temp_interval_reg};

    assign trial_shift = {rem_reg, quo_reg[SAMPLE_BITS-1]};
    assign trial_diff  = trial_shift - {1'b0, count_reg};
    assign div_sum     = chan_b_reg ? sum_b_reg : sum_a_reg;

    always_comb
    begin
        // samples past a saturated count are dropped
        if (&count_reg)
        begin
            acc_a     = sum_a_reg;
            acc_b     = sum_b_reg;
            acc_count = count_reg;
        end
        else
        begin
            acc_a     = sum_a_reg + SUM_BITS'(a_reg);
            acc_b     = sum_b_reg + SUM_BITS'(b_reg);
            acc_count = count_reg + COUNT_BITS'(1);
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        avg_interval_next  = avg_interval_reg;
        temp_interval_next = temp_interval_reg;
        sum_a_next         = sum_a_reg;
        sum_b_next         = sum_b_reg;
        count_next         = count_reg;
        window_start_next  = window_start_reg;
        temp_start_next    = temp_start_reg;
        held_a_next        = held_a_reg;
        held_b_next        = held_b_reg;
        held_temp_next     = held_temp_reg;
        rem_next           = rem_reg;
        quo_next           = quo_reg;
        step_next          = step_reg;
        chan_b_next        = chan_b_reg;
        out_valid_next     = out_valid_reg;
        out_a_next         = out_a_reg;
        out_b_next         = out_b_reg;
        out_temp_next      = out_temp_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AVERAGE_INTERVAL: avg_interval_next  = cfg_data[INTERVAL_BITS-1:0];
                REG_TEMP_INTERVAL:    temp_interval_next = cfg_data[INTERVAL_BITS-1:0];
                default:              ;
            endcase
        end

        if (out_valid_reg && result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_ch.valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                sum_a_next = acc_a;
                sum_b_next = acc_b;
                count_next = acc_count;
                if (temp_due)
                begin
                    held_temp_next  = traw_reg;
                    temp_start_next = now_reg;
                end
                if (window_close)
                begin
                    window_start_next = now_reg;
                    chan_b_next       = 1'b0;
                    if (acc_count != '0)
                    begin
                        state_next = ST_DIV_LOAD;
                    end
                    else
                    begin
                        sum_a_next = '0;
                        sum_b_next = '0;
                        count_next = '0;
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV_LOAD:
            begin
                // top bits stay below the count, as the quotient fits the sample width
                rem_next   = div_sum[SUM_BITS-1:SAMPLE_BITS];
                quo_next   = div_sum[SAMPLE_BITS-1:0];
                step_next  = '0;
                state_next = ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                if (trial_diff[COUNT_BITS])
                begin
                    rem_next = trial_shift[COUNT_BITS-1:0];
                    quo_next = {quo_reg[SAMPLE_BITS-2:0], 1'b0};
                end
                else
                begin
                    rem_next = trial_diff[COUNT_BITS-1:0];
                    quo_next = {quo_reg[SAMPLE_BITS-2:0], 1'b1};
                end
                step_next = step_reg + STEP_BITS'(1);
                if (step_reg == LAST_STEP)
                begin
                    if (chan_b_reg)
                    begin
                        held_b_next = quo_next;
                        sum_a_next  = '0;
                        sum_b_next  = '0;
                        count_next  = '0;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        held_a_next = quo_next;
                        chan_b_next = 1'b1;
                        state_next  = ST_DIV_LOAD;
                    end
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || result_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_a_next     = held_a_reg;
                    out_b_next     = held_b_reg;
                    out_temp_next  = held_temp_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_interval_reg  <= AVERAGE_INTERVAL_RESET;
            temp_interval_reg <= TEMP_INTERVAL_RESET;
            sum_a_reg         <= '0;
            sum_b_reg         <= '0;
            count_reg         <= '0;
            window_start_reg  <= '0;
            temp_start_reg    <= '0;
            held_a_reg        <= '0;
            held_b_reg        <= '0;
            held_temp_reg     <= '0;
            chan_b_reg        <= 1'b0;
            step_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            avg_interval_reg  <= avg_interval_next;
            temp_interval_reg <= temp_interval_next;
            sum_a_reg         <= sum_a_next;
            sum_b_reg         <= sum_b_next;
            count_reg         <= count_next;
            window_start_reg  <= window_start_next;
            temp_start_reg    <= temp_start_next;
            held_a_reg        <= held_a_next;
            held_b_reg        <= held_b_next;
            held_temp_reg     <= held_temp_next;
            chan_b_reg        <= chan_b_next;
            step_reg          <= step_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ch.valid && sample_ch.ready)
        begin
            now_reg  <= sample_ch.now_ms;
            a_reg    <= sample_ch.sample_a;
            b_reg    <= sample_ch.sample_b;
            traw_reg <= sample_ch.temp_raw;
        end
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        out_a_reg    <= out_a_next;
        out_b_reg    <= out_b_next;
        out_temp_reg <= out_temp_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        sample_ch.valid && sample_ch.ready |=> state_reg == ST_UPDATE)
        else $error("accepted word did not start an update");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV_LOAD |-> count_reg != '0)
        else $error("division started with a zero count");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV_STEP |-> rem_reg < count_reg)
        else $error("divider remainder not below the count");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("output word raised outside completion");

endmodule
